// ----- hdl/battery_voltage_supervisor_top_defines.svh -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor assertion macros
// Shared property wrappers, all clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_SUPERVISOR_TOP_DEFINES_SVH
`define BATTERY_VOLTAGE_SUPERVISOR_TOP_DEFINES_SVH

// Same-cycle implication
`define BVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor package
// Command codes, register indexes and the structs shared between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvs_pkg;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [1:0] CMD_BOOT     = 2'd1;
  localparam logic [1:0] CMD_LED_CHK  = 2'd2;
  localparam logic [1:0] CMD_CLR_FLAG = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_LOW_LEVEL   = 3'd0;
  localparam logic [2:0] REG_SD_LEVEL    = 3'd1;
  localparam logic [2:0] REG_BOOT_FLOOR  = 3'd2;
  localparam logic [2:0] REG_LED_INTVL   = 3'd3;
  localparam logic [2:0] REG_UNDER_LIMIT = 3'd4;

  // Register reset values
  localparam logic [15:0] LOW_LEVEL_RST   = 16'd3320;
  localparam logic [15:0] SD_LEVEL_RST    = 16'd3045;
  localparam logic [15:0] BOOT_FLOOR_RST  = 16'd2000;
  localparam logic [31:0] LED_INTVL_RST   = 32'd30000;
  localparam logic [7:0]  UNDER_LIMIT_RST = 8'd2;

  // Charge limits
  localparam logic [6:0] CHARGE_FULL = 7'd100;

  typedef struct packed {
    logic [15:0] low_level_mv;
    logic [15:0] shutdown_level_mv;
    logic [15:0] boot_floor_mv;
    logic [31:0] low_led_interval_ms;
    logic [7:0]  under_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] voltage_mv;
    logic [6:0]  charge_percent;
    logic        usb_powered;
    logic [39:0] uptime_ms;
  } item_t;

  typedef struct packed {
    logic       shutdown_flag;
    logic       low_led_on;
    logic       sleep_request;
    logic       charge_changed;
    logic [6:0] reported_charge;
  } result_t;

endpackage

// ----- hdl/bvs_cfg.sv -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor configuration registers
// Holds the thresholds and limits written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvs_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata,
  output bvs_pkg::cfg_t cfg
);

  bvs_pkg::cfg_t cfg_r;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_level_mv        <= bvs_pkg::LOW_LEVEL_RST;
      cfg_r.shutdown_level_mv   <= bvs_pkg::SD_LEVEL_RST;
      cfg_r.boot_floor_mv       <= bvs_pkg::BOOT_FLOOR_RST;
      cfg_r.low_led_interval_ms <= bvs_pkg::LED_INTVL_RST;
      cfg_r.under_count_limit   <= bvs_pkg::UNDER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bvs_pkg::REG_LOW_LEVEL:   cfg_r.low_level_mv        <= cfg_wdata[15:0];
        bvs_pkg::REG_SD_LEVEL:    cfg_r.shutdown_level_mv   <= cfg_wdata[15:0];
        bvs_pkg::REG_BOOT_FLOOR:  cfg_r.boot_floor_mv       <= cfg_wdata[15:0];
        bvs_pkg::REG_LED_INTVL:   cfg_r.low_led_interval_ms <= cfg_wdata;
        bvs_pkg::REG_UNDER_LIMIT: cfg_r.under_count_limit   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bvs_core.sv -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor core
// Supervisor state and the single-pass update for one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvs_core #(
  parameter int BOOT_SAMPLES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bvs_pkg::item_t   item,
  input  bvs_pkg::cfg_t    cfg,
  output bvs_pkg::result_t result
);

  localparam int IDX_W    = $clog2(BOOT_SAMPLES);
  localparam int SUM_W    = 16 + IDX_W;
  localparam int THR_W    = SUM_W + 1;
  localparam int BOOT_DIV = BOOT_SAMPLES - 2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BOOT_SAMPLES - 1);

  // State
  logic [6:0]       charge_r,    charge_nxt;
  logic [7:0]       under_cnt_r, under_cnt_nxt;
  logic             sd_r,        sd_nxt;
  logic [15:0]      volt_r,      volt_nxt;
  logic             led_r,       led_nxt;
  logic [39:0]      led_time_r,  led_time_nxt;
  logic [IDX_W-1:0] boot_idx_r,  boot_idx_nxt;
  logic [SUM_W-1:0] boot_sum_r,  boot_sum_nxt;
  logic [15:0]      boot_max_r,  boot_max_nxt;
  logic [15:0]      boot_min_r,  boot_min_nxt;

  // Working values
  logic [6:0]       chg;
  logic [7:0]       cnt_inc;
  logic             sleep;
  logic             changed;
  logic [SUM_W-1:0] sum_upd;
  logic [15:0]      max_upd;
  logic [15:0]      min_upd;
  logic [SUM_W-1:0] trimmed;
  logic [THR_W-1:0] thr_hi;
  logic [THR_W-1:0] thr_lo;
  logic             led_allowed;

  // Mean bounds scaled by the divisor, so the trimmed sum is compared directly:
  // mean <= shutdown  <=>  trimmed < (shutdown + 1) * div
  // mean >  floor     <=>  trimmed >= (floor + 1) * div
  assign thr_hi = (THR_W'(cfg.shutdown_level_mv) + THR_W'(1)) * THR_W'(BOOT_DIV);
  assign thr_lo = (THR_W'(cfg.boot_floor_mv) + THR_W'(1)) * THR_W'(BOOT_DIV);

  // Boot accumulator updates
  assign sum_upd = boot_sum_r + SUM_W'(item.voltage_mv);
  assign max_upd = (item.voltage_mv >= boot_max_r) ? item.voltage_mv : boot_max_r;
  assign min_upd = (item.voltage_mv < boot_min_r) ? item.voltage_mv : boot_min_r;
  assign trimmed = sum_upd - SUM_W'(max_upd) - SUM_W'(min_upd);

  // Saturating undervoltage count
  assign cnt_inc = (under_cnt_r == 8'hFF) ? under_cnt_r : under_cnt_r + 8'd1;

  // Clamp the gauge reading to full charge
  assign chg = (item.charge_percent > bvs_pkg::CHARGE_FULL) ?
               bvs_pkg::CHARGE_FULL : item.charge_percent;

  // LED rate limit: first assertion, or enough time since the last one
  assign led_allowed = (led_time_r == 40'd0) ||
                       ((item.uptime_ms > led_time_r) &&
                        ((item.uptime_ms - led_time_r) > {8'd0, cfg.low_led_interval_ms}));

  // Next state for the command
  always_comb begin
    charge_nxt    = charge_r;
    under_cnt_nxt = under_cnt_r;
    sd_nxt        = sd_r;
    volt_nxt      = volt_r;
    led_nxt       = led_r;
    led_time_nxt  = led_time_r;
    boot_idx_nxt  = boot_idx_r;
    boot_sum_nxt  = boot_sum_r;
    boot_max_nxt  = boot_max_r;
    boot_min_nxt  = boot_min_r;
    sleep         = 1'b0;
    changed       = 1'b0;
    case (item.cmd)
      bvs_pkg::CMD_SAMPLE: begin
        volt_nxt = item.voltage_mv;
        if (item.voltage_mv > cfg.low_level_mv) begin
          sd_nxt = 1'b0;
        end
        if (!item.usb_powered) begin
          if (item.voltage_mv < cfg.low_level_mv) begin
            if (item.voltage_mv < cfg.shutdown_level_mv) begin
              under_cnt_nxt = cnt_inc;
              sleep         = (cnt_inc > cfg.under_count_limit);
            end else begin
              under_cnt_nxt = 8'd0;
            end
          end else begin
            led_nxt = 1'b0;
          end
        end
        // Charge only falls, or rises while on USB
        if ((chg != charge_r) && ((chg < charge_r) || item.usb_powered)) begin
          charge_nxt = chg;
          changed    = 1'b1;
        end
      end
      bvs_pkg::CMD_BOOT: begin
        if (boot_idx_r == '0) begin
          sd_nxt = 1'b0;
        end
        if (boot_idx_r == IDX_LAST) begin
          if (({1'b0, trimmed} < thr_hi) && ({1'b0, trimmed} >= thr_lo)) begin
            sd_nxt = 1'b1;
          end
          boot_idx_nxt = '0;
          boot_sum_nxt = '0;
          boot_max_nxt = 16'd0;
          boot_min_nxt = 16'hFFFF;
        end else begin
          boot_idx_nxt = boot_idx_r + IDX_W'(1);
          boot_sum_nxt = sum_upd;
          boot_max_nxt = max_upd;
          boot_min_nxt = min_upd;
        end
      end
      bvs_pkg::CMD_LED_CHK: begin
        if (led_allowed && (volt_r < cfg.low_level_mv) &&
            (volt_r > cfg.shutdown_level_mv) && !item.usb_powered) begin
          led_nxt      = 1'b1;
          led_time_nxt = item.uptime_ms;
        end
      end
      bvs_pkg::CMD_CLR_FLAG: begin
        sd_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Advance state on each transfer into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_r    <= bvs_pkg::CHARGE_FULL;
      under_cnt_r <= 8'd0;
      sd_r        <= 1'b0;
      volt_r      <= 16'd0;
      led_r       <= 1'b0;
      led_time_r  <= 40'd0;
      boot_idx_r  <= '0;
      boot_sum_r  <= '0;
      boot_max_r  <= 16'd0;
      boot_min_r  <= 16'hFFFF;
    end else if (fire) begin
      charge_r    <= charge_nxt;
      under_cnt_r <= under_cnt_nxt;
      sd_r        <= sd_nxt;
      volt_r      <= volt_nxt;
      led_r       <= led_nxt;
      led_time_r  <= led_time_nxt;
      boot_idx_r  <= boot_idx_nxt;
      boot_sum_r  <= boot_sum_nxt;
      boot_max_r  <= boot_max_nxt;
      boot_min_r  <= boot_min_nxt;
    end
  end

  // Result reflects the state after this item
  assign result.reported_charge = charge_nxt;
  assign result.charge_changed  = changed;
  assign result.sleep_request   = sleep;
  assign result.low_led_on      = led_nxt;
  assign result.shutdown_flag   = sd_nxt;

endmodule

// ----- hdl/battery_voltage_supervisor_top.sv -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor top level
// Input register, supervisor core and result register on stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ channel (tuser = command, tdata = reading,
//   charge, USB flag and uptime). Every command yields exactly one result on
//   the out_ channel with the reported charge and the status flags.
//   Thresholds are set through the cfg_ write port while no command is in
//   flight; a write takes effect at the next clock edge.
//   The core works on the command held in the input register, and the result
//   register takes the outcome when it is free or being drained. Throughput
//   is one command per cycle while the receiver keeps taking results; the
//   whole update is one pass of compares and adds between the two registers.
//   When the receiver stalls, the result register holds its transfer and the
//   input register still takes one more command, after which in_tready drops
//   until the result is taken.
//   Synchronous reset clears both stages, the thresholds to their defaults and
//   the supervisor state (reported charge 100, counters and flags clear).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "battery_voltage_supervisor_top_defines.svh"

module battery_voltage_supervisor_top #(
  parameter int BOOT_SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // voltage_mv[15:0], charge_percent[22:16], usb_powered[23], uptime_ms[63:24]
  input  logic [63:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // reported_charge[6:0], charge_changed[7], sleep_request[8], low_led_on[9],
  // shutdown_flag[10], zero[15:11]
  output logic [15:0] out_tdata,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic             in_valid_r;
  bvs_pkg::item_t   item_r;
  logic             out_valid_r;
  bvs_pkg::result_t result_r;
  bvs_pkg::result_t result;
  bvs_pkg::cfg_t    cfg;
  logic             advance;

  // Move the held item on when the result stage is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd            <= in_tuser;
      item_r.voltage_mv     <= in_tdata[15:0];
      item_r.charge_percent <= in_tdata[22:16];
      item_r.usb_powered    <= in_tdata[23];
      item_r.uptime_ms      <= in_tdata[63:24];
    end
  end

  bvs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bvs_core #(
    .BOOT_SAMPLES (BOOT_SAMPLES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, result_r};

  // Checks
  `BVS_ASSERT_NOW(a_charge_range, out_valid_r, result_r.reported_charge <= bvs_pkg::CHARGE_FULL, "reported charge above full")
  `BVS_ASSERT_NOW(a_no_overrun, in_valid_r && out_valid_r && !out_tready, !in_tready, "input register overrun while result stalled")
  `BVS_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "transfer into result stage lost")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Battery voltage supervisor regression bench
// Drives commands on the input stream and checks every status transfer on the
// result stream against a cycle-free predictor of the supervisor, under
// several threshold settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int BOOT_SAMPLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [31:0] cfg_wdata  = '0;

  // Bench-side copies of the thresholds, used to aim readings
  logic [15:0] cur_low      = bvs_pkg::LOW_LEVEL_RST;
  logic [15:0] cur_sd       = bvs_pkg::SD_LEVEL_RST;
  logic [15:0] cur_floor    = bvs_pkg::BOOT_FLOOR_RST;
  logic [31:0] cur_interval = bvs_pkg::LED_INTVL_RST;

  logic [39:0] now_ms      = '0;
  logic [6:0]  gauge       = 7'd100;
  int          sent_items  = 0;
  int          cycle_count = 0;

  // --------------------------------------------------------------------------
  // Supervisor predictor and queue of status words still due
  // --------------------------------------------------------------------------
  class supervisor_scoreboard;
    bvs_pkg::cfg_t    cfg;
    logic [6:0]       last_charge;
    logic [7:0]       under_count;
    bit               sd_flag;
    bit               led_flag;
    logic [15:0]      last_mv;
    logic [39:0]      led_stamp;
    int unsigned      boot_count;
    int unsigned      boot_total;
    logic [15:0]      boot_hi;
    logic [15:0]      boot_lo;
    bvs_pkg::result_t status_due[$];
    int               fail_count;

    function new();
      cfg.low_level_mv        = bvs_pkg::LOW_LEVEL_RST;
      cfg.shutdown_level_mv   = bvs_pkg::SD_LEVEL_RST;
      cfg.boot_floor_mv       = bvs_pkg::BOOT_FLOOR_RST;
      cfg.low_led_interval_ms = bvs_pkg::LED_INTVL_RST;
      cfg.under_count_limit   = bvs_pkg::UNDER_LIMIT_RST;
      last_charge = bvs_pkg::CHARGE_FULL;
      under_count = '0;
      sd_flag     = 1'b0;
      led_flag    = 1'b0;
      last_mv     = '0;
      led_stamp   = '0;
      fail_count  = 0;
      clear_boot();
    endfunction

    function void clear_boot();
      boot_count = 0;
      boot_total = 0;
      boot_hi    = 16'h0000;
      boot_lo    = 16'hFFFF;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      case (addr)
        bvs_pkg::REG_LOW_LEVEL:   cfg.low_level_mv        = data[15:0];
        bvs_pkg::REG_SD_LEVEL:    cfg.shutdown_level_mv   = data[15:0];
        bvs_pkg::REG_BOOT_FLOOR:  cfg.boot_floor_mv       = data[15:0];
        bvs_pkg::REG_LED_INTVL:   cfg.low_led_interval_ms = data;
        bvs_pkg::REG_UNDER_LIMIT: cfg.under_count_limit   = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // Work out the status word that one accepted command produces
    function void note_command(bvs_pkg::item_t it);
      bvs_pkg::result_t r;
      logic [6:0]       chg;
      int unsigned      mean;
      bit               allowed;
      r   = '0;
      chg = (it.charge_percent > bvs_pkg::CHARGE_FULL) ? bvs_pkg::CHARGE_FULL
                                                        : it.charge_percent;
      case (it.cmd)
        bvs_pkg::CMD_SAMPLE: begin
          last_mv = it.voltage_mv;
          if (it.voltage_mv > cfg.low_level_mv) sd_flag = 1'b0;
          if (!it.usb_powered) begin
            if (it.voltage_mv < cfg.low_level_mv) begin
              if (it.voltage_mv < cfg.shutdown_level_mv) begin
                if (under_count != 8'hFF) under_count = under_count + 8'd1;
                if (under_count > cfg.under_count_limit) r.sleep_request = 1'b1;
              end else begin
                under_count = '0;
              end
            end else begin
              led_flag = 1'b0;
            end
          end
          // Charge may only fall, or rise while on USB
          if (chg != last_charge && (chg < last_charge || it.usb_powered)) begin
            last_charge      = chg;
            r.charge_changed = 1'b1;
          end
        end
        bvs_pkg::CMD_BOOT: begin
          if (boot_count == 0) sd_flag = 1'b0;
          boot_total = boot_total + it.voltage_mv;
          if (it.voltage_mv >= boot_hi) boot_hi = it.voltage_mv;
          if (it.voltage_mv < boot_lo) boot_lo = it.voltage_mv;
          boot_count++;
          if (boot_count >= BOOT_SAMPLES) begin
            mean = (boot_total - boot_hi - boot_lo) / (BOOT_SAMPLES - 2);
            if (mean <= cfg.shutdown_level_mv && mean > cfg.boot_floor_mv) sd_flag = 1'b1;
            clear_boot();
          end
        end
        bvs_pkg::CMD_LED_CHK: begin
          allowed = (led_stamp == 0) ||
                    (it.uptime_ms > led_stamp &&
                     (it.uptime_ms - led_stamp) > {8'd0, cfg.low_led_interval_ms});
          if (allowed && last_mv < cfg.low_level_mv &&
              last_mv > cfg.shutdown_level_mv && !it.usb_powered) begin
            led_flag  = 1'b1;
            led_stamp = it.uptime_ms;
          end
        end
        bvs_pkg::CMD_CLR_FLAG: sd_flag = 1'b0;
        default: ;
      endcase
      r.reported_charge = last_charge;
      r.low_led_on      = led_flag;
      r.shutdown_flag   = sd_flag;
      status_due.push_back(r);
    endfunction

    // Compare one status transfer with the oldest due word
    function void check_status(bvs_pkg::result_t got);
      bvs_pkg::result_t want;
      if (status_due.size() == 0) begin
        if (fail_count < 10)
          $display("status transfer with nothing due: %h", got);
        fail_count++;
        return;
      end
      want = status_due.pop_front();
      if (got.reported_charge !== want.reported_charge ||
          got.charge_changed  !== want.charge_changed  ||
          got.sleep_request   !== want.sleep_request   ||
          got.low_led_on      !== want.low_led_on      ||
          got.shutdown_flag   !== want.shutdown_flag) begin
        if (fail_count < 10)
          $display("status mismatch: want chg %0d upd %b slp %b led %b sd %b, got chg %0d upd %b slp %b led %b sd %b",
                   want.reported_charge, want.charge_changed, want.sleep_request,
                   want.low_led_on, want.shutdown_flag,
                   got.reported_charge, got.charge_changed, got.sleep_request,
                   got.low_led_on, got.shutdown_flag);
        fail_count++;
      end
    endfunction
  endclass

  supervisor_scoreboard sb = new();

  battery_voltage_supervisor_top #(
    .BOOT_SAMPLES(BOOT_SAMPLES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle shares: sender light then heavy, receiver the other way, then none
  function automatic int sender_idle_pct();
    return (sent_items < 450) ? 20 : (sent_items < 900) ? 59 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (sent_items < 450) ? 59 : (sent_items < 900) ? 20 : 0;
  endfunction

  // Drive the receiver ready
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
  end

  // Watch both channels; values seen here are those before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_status(bvs_pkg::result_t'(out_tdata[10:0]));
      if (in_tvalid && in_tready) begin
        sb.note_command('{cmd: in_tuser, voltage_mv: in_tdata[15:0],
                          charge_percent: in_tdata[22:16], usb_powered: in_tdata[23],
                          uptime_ms: in_tdata[63:24]});
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("battery_voltage_supervisor_top regression: fail");
      $finish;
    end
  end

  function automatic bvs_pkg::item_t make_item(logic [1:0] cmd, logic [15:0] mv,
                                               logic [6:0] chg, logic usb,
                                               logic [39:0] t);
    bvs_pkg::item_t it;
    it.cmd            = cmd;
    it.voltage_mv     = mv;
    it.charge_percent = chg;
    it.usb_powered    = usb;
    it.uptime_ms      = t;
    return it;
  endfunction

  // Offer one command, with a random idle gap first, and hold until transfer
  task automatic push_item(input bvs_pkg::item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {it.uptime_ms, it.usb_powered, it.charge_percent, it.voltage_mv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  // Load all thresholds; junk above each register's width must be dropped
  task automatic set_thresholds(input logic [15:0] low, input logic [15:0] sd,
                                input logic [15:0] floor_mv, input logic [31:0] intvl,
                                input logic [7:0] limit);
    cfg_write(bvs_pkg::REG_LOW_LEVEL,   {16'($urandom), low});
    cfg_write(bvs_pkg::REG_SD_LEVEL,    {16'($urandom), sd});
    cfg_write(bvs_pkg::REG_BOOT_FLOOR,  {16'($urandom), floor_mv});
    cfg_write(bvs_pkg::REG_LED_INTVL,   intvl);
    cfg_write(bvs_pkg::REG_UNDER_LIMIT, {24'($urandom), limit});
    // Index beyond the register list: no effect
    cfg_write(3'($urandom_range(5, 7)), $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_low      = low;
    cur_sd       = sd;
    cur_floor    = floor_mv;
    cur_interval = intvl;
  endtask

  function automatic logic [15:0] near_mv(logic [15:0] x);
    return x + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  // Readings aimed at the threshold edges, inside the bands and across the full range
  function automatic logic [15:0] pick_mv();
    case ($urandom_range(0, 7))
      0: return near_mv(cur_low);
      1: return near_mv(cur_sd);
      2: return 16'($urandom_range(cur_sd, cur_low));
      3: return 16'($urandom_range(0, cur_sd));
      4: return 16'($urandom);
      5: return near_mv(cur_floor);
      6: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(cur_low, 65535));
    endcase
  endfunction

  // Advance the uptime, around the LED interval, sometimes backwards
  function automatic logic [39:0] next_uptime();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: now_ms = now_ms + 40'($urandom_range(0, 1000));
      4, 5:       now_ms = now_ms + {8'd0, cur_interval} + 40'($urandom_range(0, 4)) - 40'd2;
      6:          now_ms = now_ms + 40'($urandom);
      7:          now_ms = now_ms - 40'($urandom_range(0, 1000));
      8:          now_ms = {8'($urandom), 32'($urandom)};
      default: ;
    endcase
    return now_ms;
  endfunction

  // Gauge reading drifting down, or up on USB, now and then above full
  function automatic logic [6:0] next_charge(bit rising);
    if ($urandom_range(0, 19) == 0) return 7'($urandom_range(101, 127));
    if (rising) gauge = (gauge > 7'd97) ? bvs_pkg::CHARGE_FULL
                                        : gauge + 7'($urandom_range(0, 3));
    else gauge = (gauge < 7'd2) ? 7'd0 : gauge - 7'($urandom_range(0, 2));
    return gauge;
  endfunction

  // Random traffic made of discharge, boot, charging and LED episodes
  task automatic random_phase(input int n_items);
    int          target;
    int          len;
    int          k;
    logic [15:0] base;
    logic [15:0] mv;
    target = sent_items + n_items;
    while (sent_items < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(4, 16);
          repeat (len) begin
            if ($urandom_range(0, 4) == 0)
              push_item(make_item(bvs_pkg::CMD_LED_CHK, pick_mv(), next_charge(0),
                                  ($urandom_range(0, 7) == 0), next_uptime()));
            else
              push_item(make_item(bvs_pkg::CMD_SAMPLE, pick_mv(), next_charge(0),
                                  ($urandom_range(0, 9) == 0), next_uptime()));
          end
        end
        3, 4: begin
          case ($urandom_range(0, 3))
            0:       base = near_mv(cur_sd);
            1:       base = near_mv(cur_floor);
            2:       base = 16'($urandom_range(cur_floor, cur_sd));
            default: base = 16'($urandom);
          endcase
          // Mostly full rounds, sometimes a round left unfinished
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, BOOT_SAMPLES - 1)
                                            : BOOT_SAMPLES;
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
              push_item(make_item(bvs_pkg::CMD_SAMPLE, pick_mv(), next_charge(0), 1'b0,
                                  next_uptime()));
            mv = base + 16'($urandom_range(0, 40)) - 16'd20;
            if ($urandom_range(0, 9) == 0) mv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            push_item(make_item(bvs_pkg::CMD_BOOT, mv, next_charge(0), 1'($urandom),
                                next_uptime()));
          end
        end
        5: begin
          len = $urandom_range(3, 8);
          repeat (len)
            push_item(make_item(bvs_pkg::CMD_SAMPLE, pick_mv(), next_charge(1), 1'b1,
                                next_uptime()));
        end
        6: begin
          // Park the reading inside the LED window, then poll
          push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'($urandom_range(cur_sd, cur_low)),
                              next_charge(0), 1'b0, next_uptime()));
          len = $urandom_range(2, 6);
          repeat (len)
            push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'($urandom), 7'($urandom),
                                ($urandom_range(0, 7) == 0), next_uptime()));
        end
        7: push_item(make_item(bvs_pkg::CMD_CLR_FLAG, 16'($urandom), 7'($urandom),
                               1'($urandom), next_uptime()));
        default: begin
          len = $urandom_range(1, 4);
          repeat (len)
            push_item(make_item(2'($urandom), 16'($urandom), 7'($urandom), 1'($urandom),
                                {8'($urandom), 32'($urandom)}));
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] rl;
    logic [15:0] rs;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset thresholds
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'hFFFF, 7'd100, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'h0000, 7'd0, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'h0000, 7'd127, 1'b1, 40'd0));
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'd3100, 7'd50, 1'b0, 40'd0));
    // LED: stamp still zero, uptime zero, then stamp set, earlier uptime, interval edge
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'd0, 7'd0, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'd0, 7'd0, 1'b0, 40'd1000));
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'd0, 7'd0, 1'b0, 40'd500));
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'd0, 7'd0, 1'b0, 40'd31000));
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'd0, 7'd0, 1'b0, 40'd31001));
    push_item(make_item(bvs_pkg::CMD_LED_CHK, 16'hFFFF, 7'h7F, 1'b1, 40'hFF_FFFF_FFFF));
    push_item(make_item(bvs_pkg::CMD_CLR_FLAG, 16'd0, 7'd0, 1'b0, 40'd0));
    // Boot round with both extremes trimmed off, mean lands in the shutdown band
    push_item(make_item(bvs_pkg::CMD_BOOT, 16'hFFFF, 7'd0, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_BOOT, 16'h0000, 7'd0, 1'b0, 40'd0));
    repeat (BOOT_SAMPLES - 2)
      push_item(make_item(bvs_pkg::CMD_BOOT, 16'd3000, 7'd0, 1'b0, 40'd0));
    // Equal to the low level keeps the flag, one above clears it
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'd3320, 7'd40, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'd3321, 7'd45, 1'b0, 40'd0));
    // Consecutive undervoltage until sleep is requested
    repeat (3) push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'd0, 7'd40, 1'b0, 40'd0));
    push_item(make_item(bvs_pkg::CMD_BOOT, 16'd2500, 7'd0, 1'b0, 40'd0));
    wait_drained();

    // Reset values written back explicitly
    set_thresholds(bvs_pkg::LOW_LEVEL_RST, bvs_pkg::SD_LEVEL_RST, bvs_pkg::BOOT_FLOOR_RST,
                   bvs_pkg::LED_INTVL_RST, bvs_pkg::UNDER_LIMIT_RST);
    random_phase(300);
    wait_drained();

    // Lowest settings
    set_thresholds(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'd0);
    random_phase(200);
    wait_drained();

    // Highest settings
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd254);
    random_phase(250);
    wait_drained();

    // Long undervoltage run drives the counter into saturation
    set_thresholds(bvs_pkg::LOW_LEVEL_RST, bvs_pkg::SD_LEVEL_RST, bvs_pkg::BOOT_FLOOR_RST,
                   bvs_pkg::LED_INTVL_RST, 8'd254);
    repeat (270)
      push_item(make_item(bvs_pkg::CMD_SAMPLE, 16'($urandom_range(0, 3044)), next_charge(0),
                          1'b0, next_uptime()));
    random_phase(10);
    wait_drained();

    // Random settings
    repeat (2) begin
      rl = 16'($urandom);
      rs = 16'($urandom_range(0, rl));
      set_thresholds(rl, rs, 16'($urandom_range(0, rs)),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000),
                     8'($urandom_range(0, 254)));
      random_phase(150);
      wait_drained();
    end

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("battery_voltage_supervisor_top regression: pass");
    end else begin
      $display("battery_voltage_supervisor_top regression: fail");
    end
    $finish;
  end

endmodule
